### hw/rtl/bia_pkg.sv
// Package with the widths, action codes and status codes of the bitmap ID allocator.
package bia_pkg;

  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned DIGIT_BITS = 8;
  localparam int unsigned WORD_NUM_W = 4;
  localparam int unsigned DIGIT_W    = 3;
  localparam int unsigned BIT_W      = 3;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned INDEX_REACH = 1024;

  localparam logic [1:0] ACT_ALLOC  = 2'd0;
  localparam logic [1:0] ACT_MARK   = 2'd1;
  localparam logic [1:0] ACT_UNMARK = 2'd2;
  localparam logic [1:0] ACT_TEST   = 2'd3;

  localparam logic [STATUS_W-1:0] STS_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STS_NOSPACE = 3'd1;
  localparam logic [STATUS_W-1:0] STS_RANGE   = 3'd2;
  localparam logic [STATUS_W-1:0] STS_USED    = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FREE    = 3'd4;

  localparam logic [DIGIT_BITS-1:0] DIGIT_FULL = 8'hFF;

endpackage

### hw/rtl/bitmap_id_allocator.sv
// Bitmap slot allocator that grants the lowest free slot and marks, unmarks or tests slots.
//
// Requests enter on the input channel (in_valid_i, in_stall_o) with an action and a
// slot index; each request gives exactly one result item on the output channel
// (out_valid_o, out_stall_i) with a status, a granted index and a test flag.
// The live slot count is written on the configuration channel (cfg_valid_i,
// cfg_ready_o, cfg_data_i); the user must write it only while no request is in flight,
// as the block itself does not enforce this; it is ready at all times.
// Mark, unmark and test read and update the map word in the scan state, then wait in
// the done state for the output register; an out-of-range index skips the scan state.
// Allocate reads one 64-bit map word per cycle until a word with a free live slot
// turns up, then shifts that word out one byte per cycle to find the first byte
// with a zero, then picks the bit and writes the word back.
// An allocate that finds no free slot ends with the no-space status.
// One request is worked on at a time; a new one is taken once the previous result
// sits in the output register, even if the receiver still stalls it.
// While the receiver stalls, the result item holds steady and a finished request
// waits for the output register to free up.
// Reset frees every slot at once through per-word valid bits, with no clearing
// pass, and sets the slot count to 1024.
module bitmap_id_allocator #(
  parameter int unsigned MAP_SLOTS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      action_i,
  input  logic [bia_pkg::INDEX_W-1:0]     slot_index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bia_pkg::STATUS_W-1:0]    status_o,
  output logic [bia_pkg::INDEX_W-1:0]     granted_index_o,
  output logic                            slot_used_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bia_pkg::COUNT_W-1:0]     cfg_data_i
);
  import bia_pkg::*;

  localparam int unsigned EFF_SLOTS = (MAP_SLOTS < INDEX_REACH) ? MAP_SLOTS : INDEX_REACH;
  localparam int unsigned NWORDS    = (EFF_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WAW       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned MEM_DEPTH = 2 ** WAW;
  localparam logic [COUNT_W-1:0] EFF_LIMIT = COUNT_W'(EFF_SLOTS);
  localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BYTE,
    ST_BIT,
    ST_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [1:0]            act_q, act_d;
  logic [INDEX_W-1:0]    idx_q, idx_d;
  logic [WORD_NUM_W-1:0] addr_q, addr_d;
  logic [WORD_BITS-1:0]  shift_q, shift_d;
  logic [WORD_BITS-1:0]  word_q, word_d;
  logic [DIGIT_W-1:0]    byte_q, byte_d;
  logic [STATUS_W-1:0]   res_status_q, res_status_d;
  logic [INDEX_W-1:0]    res_grant_q, res_grant_d;
  logic                  res_used_q, res_used_d;
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [INDEX_W-1:0]    out_grant_q;
  logic                  out_used_q;
  logic [COUNT_W-1:0]    slot_count_q;

  logic [WORD_BITS-1:0]  mem_q [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]  row_valid_q;
  logic [WORD_BITS-1:0]  rd_data_q;
  logic                  rd_valid_q;

  logic                  wr_en;
  logic [WORD_BITS-1:0]  wr_data;
  logic [COUNT_W-1:0]    lim;
  logic [COUNT_W-1:0]    lim_m1;
  logic [WORD_BITS-1:0]  word;
  logic [WORD_BITS-1:0]  mask;
  logic [WORD_BITS-1:0]  masked;
  logic [WORD_BITS-1:0]  idx_bit;
  logic [WORD_BITS-1:0]  alloc_bit;
  logic                  hit;
  logic [BIT_W-1:0]      bit_pos;
  logic                  out_free;
  logic                  in_accept;

  assign lim    = (slot_count_q < EFF_LIMIT) ? slot_count_q : EFF_LIMIT;
  assign lim_m1 = lim - COUNT_W'(1);
  assign word   = rd_valid_q ? rd_data_q : '0;
  assign hit    = word[idx_q[5:0]];
  assign idx_bit   = WORD_BITS'(1) << idx_q[5:0];
  assign alloc_bit = WORD_BITS'(1) << {byte_q, bit_pos};
  assign masked = word | mask;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if ({1'b0, addr_q} < lim[COUNT_W-1:6]) begin
      mask = '0;
    end else if ({1'b0, addr_q} == lim[COUNT_W-1:6]) begin
      mask = ONES << lim[5:0];
    end else begin
      mask = ONES;
    end
  end

  always_comb begin
    bit_pos = '0;
    for (int i = DIGIT_BITS - 1; i >= 0; i--) begin
      if (!shift_q[i]) begin
        bit_pos = BIT_W'(i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    idx_d        = idx_q;
    addr_d       = addr_q;
    shift_d      = shift_q;
    word_d       = word_q;
    byte_d       = byte_q;
    res_status_d = res_status_q;
    res_grant_d  = res_grant_q;
    res_used_d   = res_used_q;
    wr_en        = 1'b0;
    wr_data      = word;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          act_d        = action_i;
          idx_d        = slot_index_i;
          res_status_d = STS_OK;
          res_grant_d  = '0;
          res_used_d   = 1'b0;
          if (action_i == ACT_ALLOC) begin
            addr_d = '0;
            if (lim == '0) begin
              res_status_d = STS_NOSPACE;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end else begin
            addr_d = slot_index_i[INDEX_W-1:6];
            if ({1'b0, slot_index_i} >= lim) begin
              res_status_d = STS_RANGE;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        case (act_q)
          ACT_ALLOC: begin
            if (&masked) begin
              if (addr_q == lim_m1[INDEX_W-1:6]) begin
                res_status_d = STS_NOSPACE;
                state_d      = ST_DONE;
              end else begin
                addr_d = addr_q + WORD_NUM_W'(1);
              end
            end else begin
              word_d  = word;
              shift_d = masked;
              byte_d  = '0;
              state_d = ST_BYTE;
            end
          end
          ACT_MARK: begin
            if (hit) begin
              res_status_d = STS_USED;
            end else begin
              wr_en   = 1'b1;
              wr_data = word | idx_bit;
            end
            state_d = ST_DONE;
          end
          ACT_UNMARK: begin
            if (!hit) begin
              res_status_d = STS_FREE;
            end else begin
              wr_en   = 1'b1;
              wr_data = word & ~idx_bit;
            end
            state_d = ST_DONE;
          end
          default: begin
            res_used_d = hit;
            state_d    = ST_DONE;
          end
        endcase
      end
      ST_BYTE: begin
        if (shift_q[DIGIT_BITS-1:0] == DIGIT_FULL) begin
          shift_d = shift_q >> DIGIT_BITS;
          byte_d  = byte_q + DIGIT_W'(1);
        end else begin
          state_d = ST_BIT;
        end
      end
      ST_BIT: begin
        wr_en        = 1'b1;
        wr_data      = word_q | alloc_bit;
        res_grant_d  = {addr_q, byte_q, bit_pos};
        res_status_d = STS_OK;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr_q[WAW-1:0]] <= wr_data;
    end
    rd_data_q <= mem_q[addr_d[WAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_q[addr_q[WAW-1:0]] <= 1'b1;
      end
      rd_valid_q <= row_valid_q[addr_d[WAW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= COUNT_W'(INDEX_REACH);
    end else if (cfg_valid_i && cfg_ready_o) begin
      slot_count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    idx_q        <= idx_d;
    addr_q       <= addr_d;
    shift_q      <= shift_d;
    word_q       <= word_d;
    byte_q       <= byte_d;
    res_status_q <= res_status_d;
    res_grant_q  <= res_grant_d;
    res_used_q   <= res_used_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      out_status_q <= STS_OK;
      out_grant_q  <= '0;
      out_used_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q  <= 1'b1;
        out_status_q <= res_status_q;
        out_grant_q  <= res_grant_q;
        out_used_q   <= res_used_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign granted_index_o = out_grant_q;
  assign slot_used_o     = out_used_q;

endmodule
